@@ hw/rtl/lzme_pkg.sv @@
package lzme_pkg;

    localparam int WINDOW_DEPTH_DEF    = 1024;
    localparam int LOOKAHEAD_DEPTH_DEF = 16;
    localparam int MAX_TOKENS          = 16;

    localparam int LEN_W  = 4;
    localparam int PEND_W = 5;
    localparam int WCFG_W = 11;
    localparam int LCFG_W = 5;

    localparam logic [WCFG_W-1:0] WINDOW_RESET = WCFG_W'(1024);
    localparam logic [LCFG_W-1:0] LOOK_RESET   = LCFG_W'(16);

    typedef struct packed {
        logic hist_shift;
        logic cmp_load;
        logic cmp_shift;
        logic run_clr;
        logic run_en;
    } cell_ctrl_t;

endpackage

@@ hw/rtl/lzme_cell.sv @@
module lzme_cell
    import lzme_pkg::*;
(
    input  logic             aclk,
    input  cell_ctrl_t       ctrl,
    input  logic [7:0]       hist_prev,
    input  logic [7:0]       cmp_next,
    input  logic [7:0]       ref_byte,
    output logic [7:0]       hist_out,
    output logic [7:0]       cmp_out,
    output logic [LEN_W-1:0] run_out
);

    logic [7:0]       hist_reg;
    logic [7:0]       cmp_reg;
    logic [LEN_W-1:0] run_reg;
    logic [LEN_W-1:0] run_next;

    // run counts matches back from the far end of the lookahead
    always_comb begin
        run_next = run_reg;
        if (ctrl.run_clr) begin
            run_next = '0;
        end else if (ctrl.cmp_shift) begin
            if (ctrl.run_en && (cmp_reg == ref_byte)) begin
                run_next = run_reg + LEN_W'(1);
            end else begin
                run_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.hist_shift) begin
            hist_reg <= hist_prev;
        end
        if (ctrl.cmp_load) begin
            cmp_reg <= hist_reg;
        end else if (ctrl.cmp_shift) begin
            cmp_reg <= cmp_next;
        end
        run_reg <= run_next;
    end

    assign hist_out = hist_reg;
    assign cmp_out  = cmp_reg;
    assign run_out  = run_reg;

endmodule

@@ hw/rtl/lzme_max_tree.sv @@
module lzme_max_tree
    import lzme_pkg::*;
#(
    parameter int LEVELS = 10,
    parameter int KEY_W  = 15
) (
    input  logic             aclk,
    input  logic [KEY_W-1:0] leaf [1<<LEVELS],
    output logic [KEY_W-1:0] best
);

    localparam int N = 1 << LEVELS;

    logic [KEY_W-1:0] node_reg [1:N-1];

    // heap order: node i has children 2i and 2i+1, leaves sit at N..2N-1
    for (genvar i = 1; i < N; i++) begin : g_node
        logic [KEY_W-1:0] lhs;
        logic [KEY_W-1:0] rhs;
        if (2 * i >= N) begin : g_leaf
            assign lhs = leaf[2*i-N];
            assign rhs = leaf[2*i+1-N];
        end else begin : g_inner
            assign lhs = node_reg[2*i];
            assign rhs = node_reg[2*i+1];
        end
        always_ff @(posedge aclk) begin
            node_reg[i] <= (lhs > rhs) ? lhs : rhs;
        end
    end

    assign best = node_reg[1];

endmodule

@@ hw/rtl/lz77_match_encoder_unit.sv @@
// coding: after coding starts a token passes the load state, the compare shift through the
// cell row and the settling of the registered max tree, whose levels number log2 of the
// window depth (10 at 1024), and is emitted once the output slot is free; one byte is taken
// per cycle while no coding runs, and no byte is taken while a token is coded
// reset: synchronous active-low aresetn empties lookahead and history count and restores
// the register defaults; no clearing pass is needed
module lz77_match_encoder_unit
    import lzme_pkg::*;
#(
    parameter int WINDOW_DEPTH    = WINDOW_DEPTH_DEF,
    parameter int LOOKAHEAD_DEPTH = LOOKAHEAD_DEPTH_DEF,
    localparam int OFF_W = $clog2(WINDOW_DEPTH + 1),
    localparam int TD_W  = ((OFF_W + LEN_W + 8 + 7) / 8) * 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,   // data_byte
    input  logic            s_tlast,   // final_byte
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [TD_W-1:0] m_tdata,   // match_offset, match_length, literal_byte, zero pad
    output logic            m_tlast,   // final_token
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    localparam int SLOTS    = WINDOW_DEPTH + LOOKAHEAD_DEPTH;
    localparam int TREE_LV  = $clog2(WINDOW_DEPTH);
    localparam int TREE_N   = 1 << TREE_LV;
    localparam int KEY_W    = LEN_W + OFF_W;
    localparam int LA_IW    = $clog2(LOOKAHEAD_DEPTH);
    localparam int LOOK_TOP = (LOOKAHEAD_DEPTH < MAX_TOKENS) ? LOOKAHEAD_DEPTH : MAX_TOKENS;
    localparam logic REG_WINDOW = 1'b0;
    localparam logic REG_LOOK   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_SETTLE,
        ST_EMIT
    } state_t;

    state_t             state_reg;
    logic [WCFG_W-1:0]  win_cfg_reg;
    logic [LCFG_W-1:0]  look_cfg_reg;
    logic [PEND_W-1:0]  pend_reg;
    logic [OFF_W-1:0]   hist_count_reg;
    logic [OFF_W-1:0]   reach_reg;
    logic               last_reg;
    logic [PEND_W-1:0]  step_reg;
    logic               m_tvalid_reg;
    logic [TD_W-1:0]    m_tdata_reg;
    logic               m_tlast_reg;

    logic [7:0]         hist_arr [SLOTS];
    logic [7:0]         cmp_arr  [SLOTS];
    logic [LEN_W-1:0]   run_arr  [SLOTS];
    logic [KEY_W-1:0]   leaf     [TREE_N];
    logic [KEY_W-1:0]   best;
    logic [7:0]         la_tap   [LOOKAHEAD_DEPTH];
    cell_ctrl_t         ctrl;

    logic [PEND_W-1:0]  look_eff;
    logic [OFF_W-1:0]   win_eff;
    logic [PEND_W-1:0]  span;
    logic [PEND_W-1:0]  pend_inc;
    logic [LEN_W-1:0]   best_len;
    logic [OFF_W-1:0]   best_off;
    logic [PEND_W-1:0]  pend_after;
    logic [PEND_W-1:0]  lit_pos;
    logic [LA_IW-1:0]   lit_idx;
    logic [OFF_W:0]     hc_sum;
    logic [OFF_W-1:0]   hc_after;
    logic               in_xfer;
    logic               out_free;
    logic               cfg_wr;

    // effective register values
    always_comb begin
        if (int'(look_cfg_reg) > LOOK_TOP) begin
            look_eff = PEND_W'(LOOK_TOP);
        end else if (look_cfg_reg < LCFG_W'(2)) begin
            look_eff = PEND_W'(2);
        end else begin
            look_eff = PEND_W'(look_cfg_reg);
        end
        if (win_cfg_reg == '0) begin
            win_eff = OFF_W'(1);
        end else if (int'(win_cfg_reg) > WINDOW_DEPTH) begin
            win_eff = OFF_W'(WINDOW_DEPTH);
        end else begin
            win_eff = OFF_W'(win_cfg_reg);
        end
    end

    assign span     = (pend_reg < look_eff) ? pend_reg : look_eff;
    assign pend_inc = pend_reg + PEND_W'(1);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign cfg_wr   = psel && penable && pwrite;

    // cell control: compare step s looks at lookahead byte pend-1-s, counted while below cap
    always_comb begin
        ctrl.hist_shift = in_xfer;
        ctrl.cmp_load   = (state_reg == ST_LOAD);
        ctrl.run_clr    = (state_reg == ST_LOAD);
        ctrl.cmp_shift  = (state_reg == ST_SCAN);
        ctrl.run_en     = ((PEND_W + 1)'(step_reg) + (PEND_W + 1)'(span))
                          > (PEND_W + 1)'(pend_reg);
    end

    for (genvar j = 0; j < SLOTS; j++) begin : g_cell
        logic [7:0] hist_prev;
        logic [7:0] cmp_next;
        if (j == 0) begin : g_head
            assign hist_prev = s_tdata[7:0];
        end else begin : g_body
            assign hist_prev = hist_arr[j-1];
        end
        if (j == SLOTS - 1) begin : g_tail
            assign cmp_next = 8'h00;
        end else begin : g_mid
            assign cmp_next = cmp_arr[j+1];
        end
        lzme_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .hist_prev (hist_prev),
            .cmp_next  (cmp_next),
            .ref_byte  (cmp_arr[0]),
            .hist_out  (hist_arr[j]),
            .cmp_out   (cmp_arr[j]),
            .run_out   (run_arr[j])
        );
    end

    for (genvar i = 0; i < TREE_N; i++) begin : g_leaf
        if (i < WINDOW_DEPTH) begin : g_live
            assign leaf[i] = (OFF_W'(i + 1) <= reach_reg)
                             ? {run_arr[i+1], OFF_W'(i + 1)} : '0;
        end else begin : g_pad
            assign leaf[i] = '0;
        end
    end

    lzme_max_tree #(
        .LEVELS (TREE_LV),
        .KEY_W  (KEY_W)
    ) u_tree (
        .aclk (aclk),
        .leaf (leaf),
        .best (best)
    );

    for (genvar t = 0; t < LOOKAHEAD_DEPTH; t++) begin : g_tap
        assign la_tap[t] = hist_arr[t];
    end

    assign best_len   = best[KEY_W-1 -: LEN_W];
    assign best_off   = (best_len == '0) ? '0 : best[OFF_W-1:0];
    assign pend_after = pend_reg - PEND_W'(best_len) - PEND_W'(1);
    assign lit_pos    = pend_reg - PEND_W'(1) - PEND_W'(best_len);
    assign lit_idx    = LA_IW'(lit_pos);
    assign hc_sum     = (OFF_W + 1)'(hist_count_reg) + (OFF_W + 1)'(best_len) + (OFF_W + 1)'(1);
    assign hc_after   = (int'(hc_sum) > WINDOW_DEPTH) ? OFF_W'(WINDOW_DEPTH) : OFF_W'(hc_sum);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            win_cfg_reg    <= WINDOW_RESET;
            look_cfg_reg   <= LOOK_RESET;
            pend_reg       <= '0;
            hist_count_reg <= '0;
            last_reg       <= 1'b0;
            step_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_wr) begin
                if (paddr[2] == REG_WINDOW) begin
                    win_cfg_reg <= pwdata[WCFG_W-1:0];
                end else begin
                    look_cfg_reg <= pwdata[LCFG_W-1:0];
                end
            end
            // in the emit state a freed output slot is refilled below
            if (m_tvalid_reg && m_tready && (state_reg != ST_EMIT)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_xfer) begin
                        pend_reg <= pend_inc;
                        last_reg <= s_tlast;
                        if (s_tlast || (pend_inc >= look_eff)) begin
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                ST_LOAD: begin
                    reach_reg <= (hist_count_reg < win_eff) ? hist_count_reg : win_eff;
                    step_reg  <= '0;
                    state_reg <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (step_reg == pend_reg - PEND_W'(1)) begin
                        step_reg  <= '0;
                        state_reg <= ST_SETTLE;
                    end else begin
                        step_reg <= step_reg + PEND_W'(1);
                    end
                end
                ST_SETTLE: begin
                    if (step_reg == PEND_W'(TREE_LV - 1)) begin
                        state_reg <= ST_EMIT;
                    end else begin
                        step_reg <= step_reg + PEND_W'(1);
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= TD_W'({la_tap[lit_idx], best_len, best_off});
                        m_tlast_reg  <= last_reg && (pend_after == '0);
                        pend_reg     <= pend_after;
                        if (last_reg) begin
                            if (pend_after != '0) begin
                                hist_count_reg <= hc_after;
                                state_reg      <= ST_LOAD;
                            end else begin
                                // block ends: nothing old is searched by the next one
                                hist_count_reg <= '0;
                                last_reg       <= 1'b0;
                                state_reg      <= ST_IDLE;
                            end
                        end else begin
                            hist_count_reg <= hc_after;
                            state_reg      <= (pend_after >= look_eff) ? ST_LOAD : ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_LOOK) ? 32'(look_cfg_reg) : 32'(win_cfg_reg);

endmodule

@@ dv/tb_lz77_match_encoder_unit.sv @@
module tb_lz77_match_encoder_unit;
    import lzme_pkg::*;

    localparam int WDEPTH     = 1024;
    localparam int LDEPTH     = 16;
    localparam int RING_SLOTS = WDEPTH + LDEPTH;
    localparam int CYCLE_CAP  = 600000;
    localparam int DRAIN_WAIT = 80;

    localparam logic [2:0] ADDR_WINDOW = 3'd0;
    localparam logic [2:0] ADDR_LOOK   = 3'd4;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } byte_item_t;

    typedef struct packed {
        logic [10:0] offset;
        logic [3:0]  length;
        logic [7:0]  literal;
        logic        fin;
    } triple_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // data_byte
    logic        s_tlast;   // final_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // match_offset, match_length, literal_byte, zero pad
    logic        m_tlast;   // final_token
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lz77_match_encoder_unit u_top (.*);

    // mirror of the encoder state
    logic [7:0]  ring [RING_SLOTS];
    int          wr_ptr, pend_cnt, hist_cnt;
    logic [10:0] win_reg;
    logic [4:0]  look_reg;

    byte_item_t  byte_queue [$];
    triple_t     triple_queue [$];
    int          errors, bytes_sent, triples_seen, cycles;
    bit          run_started, calm;
    int          src_gap, sink_gap;

    always begin
        aclk = 1'b1; #6;
        aclk = 1'b0; #6;
    end

    function automatic void code_triple(int look, bit last);
        int start, span, cap, win, reach, best_len, best_off, k;
        triple_t t;
        start = (wr_ptr + RING_SLOTS - pend_cnt) % RING_SLOTS;
        span  = pend_cnt < look ? pend_cnt : look;
        cap   = span - 1;
        win   = win_reg;
        if (win < 1) win = 1;
        if (win > WDEPTH) win = WDEPTH;
        reach = hist_cnt < win ? hist_cnt : win;
        best_len = 0;
        best_off = 0;
        // scan from the oldest start so ties keep the largest offset
        for (int d = reach; d >= 1; d--) begin
            k = 0;
            while (k < cap && ring[(start + RING_SLOTS - d + k) % RING_SLOTS]
                               == ring[(start + k) % RING_SLOTS])
                k++;
            if (k > best_len) begin
                best_len = k;
                best_off = d;
            end
        end
        t.offset  = best_off[10:0];
        t.length  = best_len[3:0];
        t.literal = ring[(start + best_len) % RING_SLOTS];
        pend_cnt -= best_len + 1;
        hist_cnt += best_len + 1;
        if (hist_cnt > WDEPTH) hist_cnt = WDEPTH;
        t.fin = last && pend_cnt == 0;
        triple_queue.insert(triple_queue.size(), t);
    endfunction

    function automatic void encode_byte(logic [7:0] b, logic last);
        int look, n;
        look = look_reg;
        if (look > 16) look = 16;
        if (look < 2) look = 2;
        n = 0;
        ring[wr_ptr] = b;
        wr_ptr = (wr_ptr + 1) % RING_SLOTS;
        pend_cnt++;
        if (last) begin
            while (pend_cnt > 0 && n < MAX_TOKENS) begin
                code_triple(look, 1'b1);
                n++;
            end
            pend_cnt = 0;
            hist_cnt = 0;
        end else begin
            while (pend_cnt >= look && n < MAX_TOKENS) begin
                code_triple(look, 1'b0);
                n++;
            end
        end
    endfunction

    function automatic void enqueue_byte(logic [7:0] d, bit f);
        byte_item_t it;
        it.data = d;
        it.fin  = f;
        byte_queue.insert(byte_queue.size(), it);
    endfunction

    // input side: feed bytes, with random bursts of gaps
    always @(posedge aclk) begin
        if (!aresetn || !run_started) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_tready) begin
            s_tvalid <= 1'b1;
        end else if (src_gap > 0) begin
            src_gap  <= src_gap - 1;
            s_tvalid <= 1'b0;
        end else if (byte_queue.size() > 0) begin
            s_tdata  <= byte_queue[0].data;
            s_tlast  <= byte_queue[0].fin;
            s_tvalid <= 1'b1;
            void'(byte_queue.pop_front());
            if (!calm && $urandom_range(0, 9) == 0) src_gap <= $urandom_range(1, 9);
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // output side: stall in bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (!calm && $urandom_range(0, 7) == 0) sink_gap <= $urandom_range(1, 9);
        end
    end

    // monitor: register mirror, byte transfers and triple checks
    always @(posedge aclk) begin
        triple_t got, want;
        if (aresetn) begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == ADDR_WINDOW) win_reg = pwdata[10:0];
                else if (paddr == ADDR_LOOK) look_reg = pwdata[4:0];
            end
            if (s_tvalid && s_tready) begin
                encode_byte(s_tdata, s_tlast);
                bytes_sent++;
            end
            if (m_tvalid && m_tready) begin
                got.offset  = m_tdata[10:0];
                got.length  = m_tdata[14:11];
                got.literal = m_tdata[22:15];
                got.fin     = m_tlast;
                triples_seen++;
                if (triple_queue.size() == 0) begin
                    $display("%0t unexpected triple: actual %h", $time, got);
                    errors++;
                end else begin
                    want = triple_queue.pop_front();
                    if (got.offset !== want.offset)
                        $display("%0t offset: expected %0d actual %0d",
                                 $time, want.offset, got.offset);
                    if (got.length !== want.length)
                        $display("%0t length: expected %0d actual %0d",
                                 $time, want.length, got.length);
                    if (got.literal !== want.literal)
                        $display("%0t literal: expected %h actual %h",
                                 $time, want.literal, got.literal);
                    if (got.fin !== want.fin)
                        $display("%0t final: expected %b actual %b",
                                 $time, want.fin, got.fin);
                    if (got !== want) errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("timeout with %0d triples outstanding", triple_queue.size());
            $display("tb: failure");
            $finish;
        end
    end

    task automatic reg_write(logic [2:0] addr, logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_regs(int win, int look);
        reg_write(ADDR_WINDOW, win);
        reg_write(ADDR_LOOK, look);
    endtask

    // wait until every queued byte has gone and every triple has come back
    task automatic drain();
        while (byte_queue.size() > 0 || s_tvalid || triple_queue.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // a block with a small alphabet and copied runs so that matches turn up
    task automatic add_block(int len, bit fin);
        logic [7:0] base, b;
        int alph;
        logic [7:0] made [$];
        base = 8'($urandom);
        alph = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
            if (made.size() > 4 && $urandom_range(0, 2) == 0)
                b = made[$urandom_range(0, made.size() - 1)];
            else if ($urandom_range(0, 9) == 0)
                b = 8'($urandom);
            else
                b = base + 8'($urandom_range(0, alph - 1));
            made.insert(made.size(), b);
            enqueue_byte(b, fin && (i == len - 1));
        end
    endtask

    initial begin
        int win, look;
        int phase;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        wr_ptr = 0;
        pend_cnt = 0;
        hist_cnt = 0;
        win_reg = WINDOW_RESET;
        look_reg = LOOK_RESET;
        errors = 0;
        bytes_sent = 0;
        triples_seen = 0;
        cycles = 0;
        run_started = 1'b0;
        calm = 1'b0;
        src_gap = 0;
        sink_gap = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_started = 1'b1;

        // directed: defaults, extreme bytes, single byte block, long repeat
        enqueue_byte(8'h00, 1'b0);
        enqueue_byte(8'hff, 1'b0);
        enqueue_byte(8'h00, 1'b0);
        enqueue_byte(8'hff, 1'b1);
        enqueue_byte(8'h5a, 1'b1);
        for (int i = 0; i < 18; i++)
            enqueue_byte(8'ha5, i == 17);
        drain();
        // window and lookahead out of range, then the smallest legal settings
        set_regs(0, 0);
        add_block(12, 1'b1);
        drain();
        set_regs(2047, 31);
        add_block(20, 1'b1);
        drain();
        set_regs(1, 2);
        add_block(10, 1'b1);
        drain();
        // lookahead shrunk while bytes are still buffered
        set_regs(1024, 16);
        add_block(14, 1'b0);
        drain();
        set_regs(1024, 3);
        add_block(8, 1'b1);
        drain();

        phase = 0;
        while (bytes_sent < 175) begin
            if ($urandom_range(0, 3) == 0) win = $urandom_range(0, 2047);
            else win = $urandom_range(1, 24);
            look = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
                                                : $urandom_range(2, 16);
            if (bytes_sent > 150) calm = 1'b1;
            set_regs(win, look);
            add_block($urandom_range(1, 30), $urandom_range(0, 5) != 0);
            if ($urandom_range(0, 1) == 0) add_block($urandom_range(1, 20), 1'b1);
            drain();
            phase++;
        end
        calm = 1'b1;
        // deep window at the full window depth with one long block
        set_regs(1024, 16);
        add_block(40, 1'b1);
        drain();

        $display("%0d bytes in %0d random phases plus directed blocks, %0d triples checked",
                 bytes_sent, phase, triples_seen);
        $display("register extremes and mid-block lookahead changes covered");
        if (errors == 0 && triple_queue.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
